// ===== sv/cmat_pkg.sv =====
// cmat_pkg: payload types, status codes and register map of the cascaded
// moving-average unit with converter timeout
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package cmat_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] RESET_POLL_INTERVAL = 16'd10;
    localparam logic [CFG_W-1:0] RESET_TIMEOUT_LIMIT = 16'd1000;

    // saturation point of the timeout accumulator
    localparam logic [CFG_W-1:0] WAIT_MAX = 16'hFFFF;

    // result status codes
    localparam logic STATUS_COMPLETE = 1'b0;
    localparam logic STATUS_ERROR    = 1'b1;

    typedef struct packed {
        logic                ready_req;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [SAMPLE_W-1:0] filtered_value;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/cascaded_moving_average_with_timeout_unit.sv =====
// cascaded_moving_average_with_timeout_unit: top level, sequencer, timeout
// accumulator, config registers and result register
// depends on cmat_pkg, cmat_stage, cmat_div
//
//  channel  | ports                              | carries
//  ---------+------------------------------------+------------------------------
//  input    | s_valid s_ready s_data             | one poll tick (ready, sample)
//  result   | m_valid m_ready m_data             | status and filtered value
//  config   | cfg_valid cfg_ready cfg_index/data | register writes, always ready
//
// a ready tick updates stage one, divides its sum by its count, updates stage two
// with that average and divides again, the bit-serial divider run once per stage
// a not-ready tick accumulates the poll interval or raises a timeout error
// a new tick is taken only while the sequencer is idle; a result waits in
// the output register and stalls the sequencer only if the next one is ready
// reset is synchronous active low and clears sums, counts, positions,
// accumulator and config registers at once; ring contents are never cleared
`timescale 1ns / 1ps
`default_nettype none

module cascaded_moving_average_with_timeout_unit #(
    parameter int FIRST_DEPTH  = 14,
    parameter int SECOND_DEPTH = 14,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cmat_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cmat_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmat_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cmat_pkg::CFG_W-1:0]          cfg_data
);

    localparam int DW   = SAMPLE_BITS;
    localparam int OW   = cmat_pkg::SAMPLE_W;
    localparam int MAXW = (DW > OW) ? DW : OW;
    localparam int INW  = (DW < OW) ? DW : OW;
    localparam int CW1  = $clog2(FIRST_DEPTH + 1);
    localparam int CW2  = $clog2(SECOND_DEPTH + 1);
    localparam int SW1  = DW + CW1;
    localparam int SW2  = DW + CW2;
    localparam int NW   = (SW1 > SW2) ? SW1 : SW2;
    localparam int DVW  = (CW1 > CW2) ? CW1 : CW2;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPD1   = 3'd1;
    localparam logic [2:0] S_START1 = 3'd2;
    localparam logic [2:0] S_DIV1   = 3'd3;
    localparam logic [2:0] S_UPD2   = 3'd4;
    localparam logic [2:0] S_START2 = 3'd5;
    localparam logic [2:0] S_DIV2   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [cmat_pkg::CFG_W-1:0]  interval_reg, interval_next;
    logic [cmat_pkg::CFG_W-1:0]  limit_reg, limit_next;
    logic [cmat_pkg::CFG_W-1:0]  wait_reg, wait_next;
    cmat_pkg::out_item_t         res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    cmat_pkg::out_item_t         out_data_reg, out_data_next;

    logic                        in_xfer;
    logic                        put1, put2;
    logic [DW-1:0]               x1, x2;
    logic [MAXW-1:0]             sample_ext;
    logic [SW1-1:0]              sum1;
    logic [SW2-1:0]              sum2;
    logic [CW1-1:0]              count1;
    logic [CW2-1:0]              count2;
    logic                        div_start;
    logic [NW-1:0]               div_dividend;
    logic [DVW-1:0]              div_divisor;
    logic                        div_done;
    logic [NW-1:0]               quot;
    logic [MAXW-1:0]             avg_ext;
    logic [cmat_pkg::CFG_W:0]    wait_sum;
    logic [cmat_pkg::CFG_W-1:0]  wait_sat;

    assign in_xfer   = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // low SAMPLE_BITS of the sample feed the first stage
    assign sample_ext = MAXW'(s_data.sample);
    assign x1         = DW'(sample_ext[INW-1:0]);
    assign x2         = DW'(quot);
    assign avg_ext    = MAXW'(x2);

    cmat_stage #(
        .DEPTH (FIRST_DEPTH),
        .DW    (DW)
    ) u_stage1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .put     (put1),
        .x       (x1),
        .sum     (sum1),
        .count   (count1)
    );

    cmat_stage #(
        .DEPTH (SECOND_DEPTH),
        .DW    (DW)
    ) u_stage2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .put     (put2),
        .x       (x2),
        .sum     (sum2),
        .count   (count2)
    );

    // shared divider, fed by whichever stage is being averaged
    assign div_start    = (state_reg == S_START1) || (state_reg == S_START2);
    assign div_dividend = (state_reg == S_START2) ? NW'(sum2) : NW'(sum1);
    assign div_divisor  = (state_reg == S_START2) ? DVW'(count2) : DVW'(count1);

    cmat_div #(
        .NW  (NW),
        .DVW (DVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    // saturating timeout accumulation
    always_comb begin
        wait_sum = {1'b0, wait_reg} + {1'b0, interval_reg};
        wait_sat = wait_sum[cmat_pkg::CFG_W] ? cmat_pkg::WAIT_MAX
                                             : wait_sum[cmat_pkg::CFG_W-1:0];
    end

    // configuration writes
    always_comb begin
        interval_next = interval_reg;
        limit_next    = limit_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == cmat_pkg::REG_POLL_INTERVAL) begin
                interval_next = cfg_data;
            end else if (cfg_index == cmat_pkg::REG_TIMEOUT_LIMIT) begin
                limit_next = cfg_data;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        res_next   = res_reg;
        put1       = 1'b0;
        put2       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_data.ready_req) begin
                        wait_next  = '0;
                        put1       = 1'b1;
                        state_next = S_UPD1;
                    end else if (wait_sat >= limit_reg) begin
                        wait_next               = '0;
                        res_next.status         = cmat_pkg::STATUS_ERROR;
                        res_next.filtered_value = '0;
                        state_next              = S_EMIT;
                    end else begin
                        wait_next = wait_sat;
                    end
                end
            end
            S_UPD1: begin
                state_next = S_START1;
            end
            S_START1: begin
                state_next = S_DIV1;
            end
            S_DIV1: begin
                if (div_done) begin
                    put2       = 1'b1;
                    state_next = S_UPD2;
                end
            end
            S_UPD2: begin
                state_next = S_START2;
            end
            S_START2: begin
                state_next = S_DIV2;
            end
            S_DIV2: begin
                if (div_done) begin
                    res_next.status         = cmat_pkg::STATUS_COMPLETE;
                    res_next.filtered_value = avg_ext[OW-1:0];
                    state_next              = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_EMIT) && (!out_valid_reg || m_ready)) begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            interval_reg  <= cmat_pkg::RESET_POLL_INTERVAL;
            limit_reg     <= cmat_pkg::RESET_TIMEOUT_LIMIT;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            interval_reg  <= interval_next;
            limit_reg     <= limit_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/cmat_ram.sv =====
// cmat_ram: generic simple dual-port ram, one write port and one
// registered read port; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cmat_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 14
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/cmat_div.sv =====
// cmat_div: bit-serial restoring divider, one quotient bit per cycle
// no dependencies; shared by both averaging stages
`timescale 1ns / 1ps
`default_nettype none

module cmat_div #(
    parameter int NW  = 28,
    parameter int DVW = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DVW-1:0]  dvs_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;

    logic [DVW:0]    rem_shift;
    logic [DVW:0]    rem_diff;
    logic            fits;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        rem_shift = {rem_reg, quo_reg[NW-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNTW'(NW);
            run_next = 1'b1;
        end else if (run_reg) begin
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? rem_diff[DVW-1:0] : rem_shift[DVW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/cmat_stage.sv =====
// cmat_stage: one running-sum moving-average stage: sample ring, sum,
// fill count and write position; depends on cmat_ram
`timescale 1ns / 1ps
`default_nettype none

module cmat_stage #(
    parameter int DEPTH = 14,
    parameter int DW    = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  put,
    input  logic [DW-1:0]                         x,
    output logic [DW+$clog2(DEPTH+1)-1:0]         sum,
    output logic [$clog2(DEPTH+1)-1:0]            count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = DW + CW;

    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          upd_reg;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] old_data;
    logic          full;

    // ring: the oldest entry sits at the write position once full
    cmat_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (upd_reg),
        .wr_addr (pos_reg),
        .wr_data (x_reg),
        .rd_en   (put),
        .rd_addr (pos_reg),
        .rd_data (old_data)
    );

    // running sum update, once the ring read data is registered
    always_comb begin
        full       = (count_reg == CW'(DEPTH));
        sum_next   = sum_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (upd_reg) begin
            sum_next = sum_reg - (full ? SW'(old_data) : '0) + SW'(x_reg);
            if (!full) begin
                count_next = count_reg + 1'b1;
            end
            pos_next = (pos_reg == AW'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            upd_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            upd_reg   <= put;
        end
    end

    // hold the new sample for the update cycle
    always_ff @(posedge aclk) begin
        if (put) begin
            x_reg <= x;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== sv/cmat_checker.sv =====
// cmat_checker: port-level assertions for the cascaded moving-average unit
// and the bind that attaches them; depends on cmat_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmat_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input cmat_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input cmat_pkg::out_item_t  m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an error result carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == cmat_pkg::STATUS_ERROR)
        |-> (m_data.filtered_value == '0))
        else $error("error result with nonzero value");

    // a sample transfer starts filtering, so no tick is taken next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.ready_req |=> !s_ready)
        else $error("tick taken while filtering");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind cascaded_moving_average_with_timeout_unit cmat_checker u_cmat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
